[hw/rtl/uart_16550_register_model_defines.svh]
// Assertion macros for the 16550 register model checker.
`ifndef UART_16550_REGISTER_MODEL_DEFINES_SVH
`define UART_16550_REGISTER_MODEL_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define U16550_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst.
`define U16550_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/u16550_pkg.sv]
// Shared types, codes and constants for the 16550 register model.
package u16550_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RX    = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  localparam logic [7:0] IIR_LINE  = 8'd6;
  localparam logic [7:0] IIR_DATA  = 8'd4;
  localparam logic [7:0] IIR_THRE  = 8'd2;
  localparam logic [7:0] IIR_NONE  = 8'd1;

  localparam logic [7:0] LSR_DR      = 8'h01;
  localparam logic [7:0] LSR_ERR     = 8'h1E;
  localparam logic [7:0] LSR_ERR_CLR = 8'h0E;
  localparam logic [7:0] LSR_THRE    = 8'h20;
  localparam logic [7:0] LSR_EMPTY   = 8'h60;
  localparam logic [7:0] MSR_CTS     = 8'h10;
  localparam logic [7:0] MSR_DCTS    = 8'h01;

  localparam int LCR_DLAB  = 7;
  localparam int MCR_AFE   = 5;

  // Input transaction payload, first field in the high bits.
  typedef struct packed {
    logic       cts_level;
    logic [7:0] line_byte;
    logic [7:0] write_data;
    logic [2:0] reg_index;
  } item_t;

  // Result payload, first field in the high bits.
  typedef struct packed {
    logic        auto_flow;
    logic        rts_out;
    logic        dtr_out;
    logic [1:0]  stop_mode;
    logic [2:0]  parity_mode;
    logic [3:0]  data_bits;
    logic [15:0] divisor;
    logic [2:0]  irq_id;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [7:0]  read_data;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

[hw/rtl/u16550_regs.sv]
// Register file, transmit/receive rings and result formatting.
module u16550_regs
  import u16550_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cmd_t    cmd,
  input  item_t   item,
  output result_t result
);

  logic [7:0] tx_ring [FIFO_DEPTH];
  logic [7:0] rx_ring [FIFO_DEPTH];
  ptr_t tx_head, tx_tail, rx_head, rx_tail;
  logic [7:0] rbr, ier, iir, lcr, mcr, lsr, msr, scr, dl_lo, dl_hi;
  logic dtr, rts;

  ptr_t tx_head_next, tx_tail_next, rx_head_next, rx_tail_next;
  logic [7:0] rbr_next, ier_next, iir_next, lcr_next, mcr_next;
  logic [7:0] lsr_next, msr_next, scr_next, dl_lo_next, dl_hi_next;
  logic dtr_next, rts_next;
  logic tx_push, rx_push;
  logic [7:0] rdata, txb;
  logic txv;

  always_comb begin
    logic dlab;
    logic [7:0] chg;
    dlab = lcr[LCR_DLAB];
    chg = '0;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    rbr_next = rbr;
    ier_next = ier;
    lcr_next = lcr;
    mcr_next = mcr;
    lsr_next = lsr;
    msr_next = msr;
    scr_next = scr;
    dl_lo_next = dl_lo;
    dl_hi_next = dl_hi;
    dtr_next = dtr;
    rts_next = rts;
    tx_push = 1'b0;
    rx_push = 1'b0;
    rdata = '0;
    txb = '0;
    txv = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        case (item.reg_index)
          REG_RBR: begin
            if (dlab) begin
              dl_lo_next = item.write_data;
            end else begin
              lsr_next = lsr & ~LSR_EMPTY;
              if (ring_next(tx_head) != tx_tail) begin
                tx_push = 1'b1;
                tx_head_next = ring_next(tx_head);
                if (ring_next(tx_head_next) != tx_tail) begin
                  lsr_next = lsr_next | LSR_EMPTY;
                end
              end
            end
          end
          REG_IER: begin
            if (dlab) dl_hi_next = item.write_data;
            else ier_next = item.write_data;
          end
          REG_LCR: lcr_next = item.write_data;
          REG_MCR: begin
            mcr_next = item.write_data;
            if (!item.write_data[MCR_AFE]) begin
              chg = mcr ^ item.write_data;
              if (chg[0]) dtr_next = item.write_data[0];
              if (chg[1]) rts_next = item.write_data[1];
            end
          end
          REG_SCR: scr_next = item.write_data;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (item.reg_index)
          REG_RBR: begin
            if (dlab) begin
              rdata = dl_lo;
            end else begin
              rdata = rbr;
              if (rx_head != rx_tail) begin
                rbr_next = rx_ring[rx_tail];
                rdata = rx_ring[rx_tail];
                rx_tail_next = ring_next(rx_tail);
              end
              if (rx_head != rx_tail_next) lsr_next = lsr | LSR_DR;
              else lsr_next = lsr & ~LSR_DR;
            end
          end
          REG_IER: rdata = dlab ? dl_hi : ier;
          REG_IIR: rdata = iir;
          REG_LCR: rdata = lcr;
          REG_MCR: rdata = mcr;
          REG_LSR: begin
            rdata = lsr;
            lsr_next = lsr & ~LSR_ERR_CLR;
          end
          REG_MSR: begin
            msr_next = (msr & ~(MSR_CTS | MSR_DCTS))
                     | (item.cts_level ? MSR_CTS : 8'h00)
                     | ((msr[4] ^ item.cts_level) ? MSR_DCTS : 8'h00);
            rdata = msr_next;
          end
          REG_SCR: rdata = scr;
          default: ;
        endcase
      end
      CMD_RX: begin
        if (ring_next(rx_head) != rx_tail) begin
          rx_push = 1'b1;
          rx_head_next = ring_next(rx_head);
        end
        lsr_next = lsr | LSR_DR;
      end
      CMD_DRAIN: begin
        if (tx_head != tx_tail) begin
          txb = tx_ring[tx_tail];
          txv = 1'b1;
          tx_tail_next = ring_next(tx_tail);
        end
        lsr_next = lsr | LSR_EMPTY;
      end
      default: ;
    endcase
    if ((lsr_next & LSR_ERR) != 8'h00) iir_next = IIR_LINE;
    else if ((lsr_next & LSR_DR) != 8'h00) iir_next = IIR_DATA;
    else if ((lsr_next & LSR_THRE) != 8'h00) iir_next = IIR_THRE;
    else iir_next = IIR_NONE;
  end

  always_comb begin
    result.read_data   = rdata;
    result.tx_valid    = txv;
    result.tx_byte     = txb;
    result.irq_id      = iir_next[2:0];
    result.divisor     = ({dl_hi_next, dl_lo_next} == 16'd0) ? 16'd1
                                                             : {dl_hi_next, dl_lo_next};
    result.data_bits   = 4'd5 + {2'b00, lcr_next[1:0]};
    result.parity_mode = lcr_next[3] ? 3'd1 + {1'b0, lcr_next[5:4]} : 3'd0;
    result.stop_mode   = !lcr_next[2] ? 2'd0 : ((lcr_next[1:0] == 2'd0) ? 2'd1 : 2'd2);
    result.dtr_out     = dtr_next;
    result.rts_out     = rts_next;
    result.auto_flow   = mcr_next[MCR_AFE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      rbr <= '0;
      ier <= '0;
      iir <= '0;
      lcr <= '0;
      mcr <= '0;
      lsr <= '0;
      msr <= '0;
      scr <= '0;
      dl_lo <= '0;
      dl_hi <= '0;
      dtr <= 1'b0;
      rts <= 1'b0;
    end else if (en) begin
      tx_head <= tx_head_next;
      tx_tail <= tx_tail_next;
      rx_head <= rx_head_next;
      rx_tail <= rx_tail_next;
      rbr <= rbr_next;
      ier <= ier_next;
      iir <= iir_next;
      lcr <= lcr_next;
      mcr <= mcr_next;
      lsr <= lsr_next;
      msr <= msr_next;
      scr <= scr_next;
      dl_lo <= dl_lo_next;
      dl_hi <= dl_hi_next;
      dtr <= dtr_next;
      rts <= rts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tx_push) tx_ring[tx_head] <= item.write_data;
    if (en && rx_push) rx_ring[rx_head] <= item.line_byte;
  end

endmodule

[hw/rtl/uart_16550_register_model.sv]
// Top level: 16550-style register model with stream input and result ports.
//
//   channel  dir  tdata                                       tuser
//   s_*      in   reg_index, write_data, line_byte, cts_level command
//   m_*      out  read_data .. auto_flow (48 bits)            -
//
// One transaction per cycle while m_tready is high; items pass the input
// register, then the register file update and result register.
// The register file and both rings update in the single cycle an item leaves
// the input register, so each item sees the state left by the one before.
// A stalled m_tready holds the result and the input register fills, then
// s_tready drops. rst is synchronous and clears all control state.
module uart_16550_register_model
  import u16550_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] reg_index, [10:3] write_data, [18:11] line_byte, [19] cts_level
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [19:17] irq_id,
  // [35:20] divisor, [39:36] data_bits, [42:40] parity_mode,
  // [44:43] stop_mode, [45] dtr_out, [46] rts_out, [47] auto_flow
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic    in_valid;
  cmd_t    in_cmd;
  item_t   in_item;
  logic    fire;
  result_t result;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_item <= s_tdata[ITEM_W-1:0];
    end
  end

  u16550_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .cmd    (in_cmd),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_TDATA_W'(result);
    end
  end

endmodule

[hw/rtl/u16550_chk.sv]
// Port-level checker for the 16550 register model, bound to the top level.
`include "uart_16550_register_model_defines.svh"

module u16550_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `U16550_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "stalled result changed")
  `U16550_ASSERT_NOW(a_div_nonzero, m_tvalid, m_tdata[35:20] != 16'd0, "divisor shown as zero")
  `U16550_ASSERT_NOW(a_bits_range, m_tvalid, m_tdata[39:36] >= 4'd5 && m_tdata[39:36] <= 4'd8, "character length out of range")
  `U16550_ASSERT_NOW(a_irq_code, m_tvalid, m_tdata[19:17] == 3'd1 || m_tdata[19:17] == 3'd2 || m_tdata[19:17] == 3'd4 || m_tdata[19:17] == 3'd6, "bad interrupt id")
  `U16550_ASSERT_NOW(a_tx_idle, m_tvalid && !m_tdata[8], m_tdata[16:9] == 8'd0, "tx byte without pop")

endmodule

bind uart_16550_register_model u16550_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
